/* rtl/jdc_pkg.sv */
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared widths, state codes and control types of the deadzone calibrator.
// ----------------------------------------------------------------------------
package jdc_pkg;

    localparam int WINDOW      = 50;
    localparam int SAMPLE_BITS = 16;
    localparam int MULT_W      = 4;
    localparam int MULT_RESET  = 5;
    localparam int CNT_W       = 9;
    localparam int BND_W       = 21;
    localparam int PCT_W       = 8;
    localparam int PCT_CAP     = 255;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int SQ_W    = $clog2(WINDOW) + 2 * SAMPLE_BITS;
    localparam int FRAC2_W = 16;                  // variance fraction bits
    localparam int VAR_W   = SQ_W + FRAC2_W;
    localparam int ROOT_W  = VAR_W / 2;
    localparam int DS_W    = VAR_W;               // shared unit operand width
    localparam int REM_W   = ROOT_W + 3;
    localparam int DEN_W   = 17;
    localparam int STEP_W  = $clog2(DS_W + 1);
    localparam int PNUM_W  = 28;                  // span * 100

    typedef struct packed {
        logic              start;
        logic              is_sqrt;
        logic [STEP_W-1:0] steps;
    } t_ds_ctl;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SUM  = 10'b00_0000_0010,
        ST_MEAN = 10'b00_0000_0100,
        ST_SQ   = 10'b00_0000_1000,
        ST_VAR  = 10'b00_0001_0000,
        ST_ROOT = 10'b00_0010_0000,
        ST_BND  = 10'b00_0100_0000,
        ST_PL   = 10'b00_1000_0000,
        ST_PH   = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } t_state;

endpackage

/* rtl/joystick_deadzone_calibrator.sv */
// ----------------------------------------------------------------------------
// joystick_deadzone_calibrator
// Sample ring, running range and deadzone calibration from window statistics.
// ----------------------------------------------------------------------------
// Each accepted beat yields exactly one result beat showing the state after
// that beat. A start beat or a sample outside calibration spends the time
// from one accept to the next mostly in the two percent divisions (28 steps
// each, plus launch and handoff); a degenerate percent skips both. A
// calibrating sample with a valid zero recomputes mean and stdev: two read
// passes over the N filled ring entries (one entry per cycle through the
// ring's single read port) plus the mean division (22 steps), variance
// division (54 steps) and square root (27 steps) on the one shared
// restoring unit. A stalled result that still holds the output register
// delays the hand-off by the length of the stall. Input stall is high
// whenever an item is being worked on; the result sits in its own output
// register so the next beat can be taken while it waits.
// ----------------------------------------------------------------------------
module joystick_deadzone_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: deadzone multiplier
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jdc_pkg::MULT_W-1:0]          i_cfg_data,
    // input items
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [15:0]                         i_sample,
    // results
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [15:0]                         o_zero_position,
    output logic                                o_zero_valid,
    output logic signed [jdc_pkg::BND_W-1:0]    o_deadzone_lower,
    output logic signed [jdc_pkg::BND_W-1:0]    o_deadzone_upper,
    output logic [15:0]                         o_range_minimum,
    output logic [15:0]                         o_range_maximum,
    output logic                                o_range_valid,
    output logic                                o_calibrating,
    output logic [jdc_pkg::CNT_W-1:0]           o_countdown,
    output logic [jdc_pkg::PCT_W-1:0]           o_deadzone_percent
);
    import jdc_pkg::*;

    localparam int M_W  = ROOT_W + MULT_W;   // multiplier * stdev
    localparam int T_W  = M_W + 2;           // signed bound temporaries
    localparam int NL_W = BND_W + 2;         // zero minus lower, upper minus zero

    function automatic logic signed [BND_W-1:0] sat_bnd(input logic signed [T_W-1:0] v);
        logic signed [T_W-1:0] hi, lo;
        begin
            hi = T_W'((1 << (BND_W - 1)) - 1);
            lo = -T_W'(1 << (BND_W - 1));
            if (v > hi) begin
                sat_bnd = hi[BND_W-1:0];
            end else if (v < lo) begin
                sat_bnd = lo[BND_W-1:0];
            end else begin
                sat_bnd = v[BND_W-1:0];
            end
        end
    endfunction

    function automatic logic [PCT_W-1:0] cap_pct(input logic [DS_W-1:0] q);
        begin
            cap_pct = (q > DS_W'(PCT_CAP)) ? PCT_W'(PCT_CAP) : q[PCT_W-1:0];
        end
    endfunction

    // ---------------- state ----------------
    t_state                  r_state;
    logic [MULT_W-1:0]       r_mult;
    logic [IDX_W-1:0]        r_wp;
    logic [FILL_W-1:0]       r_fill;
    logic [15:0]             r_zero;
    logic                    r_zv;
    logic signed [BND_W-1:0] r_lower, r_upper;
    logic [15:0]             r_min, r_max;
    logic                    r_rv;
    logic                    r_cal;
    logic [CNT_W-1:0]        r_cnt;

    // work registers
    logic [FILL_W-1:0]       r_idx;
    logic                    r_pend, r_pend2;
    logic [SQ_W-1:0]         r_acc;
    logic [2*SAMPLE_BITS-1:0] r_sqv;
    logic [DS_W-1:0]         r_var;
    logic [ROOT_W-1:0]       r_s;
    logic                    r_launch;
    logic [PCT_W-1:0]        r_pct;

    // result register
    logic                    r_ovalid;
    logic [15:0]             r_o_zero;
    logic                    r_o_zv;
    logic signed [BND_W-1:0] r_o_lower, r_o_upper;
    logic [15:0]             r_o_min, r_o_max;
    logic                    r_o_rv, r_o_cal;
    logic [CNT_W-1:0]        r_o_cnt;
    logic [PCT_W-1:0]        r_o_pct;

    // ---------------- handshakes ----------------
    logic accept, out_take, slot_free;
    logic [SAMPLE_BITS-1:0] x;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_take    = r_ovalid && !i_stall;
    assign slot_free   = !r_ovalid || !i_stall;
    assign x           = i_sample[SAMPLE_BITS-1:0];

    // ---------------- ring ----------------
    logic [SAMPLE_BITS-1:0] rdata;

    jdc_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && !i_mode),
        .i_waddr (r_wp),
        .i_wdata (x),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // ---------------- shared div / sqrt unit ----------------
    t_ds_ctl          ds_ctl;
    logic [DS_W-1:0]  ds_num;
    logic [DEN_W-1:0] ds_den;
    logic             ds_done;
    logic [DS_W-1:0]  ds_q;

    jdc_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ds_ctl),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_done  (ds_done),
        .o_q     (ds_q)
    );

    // ---------------- datapath helpers ----------------
    logic signed [SAMPLE_BITS:0] dev;
    logic [SAMPLE_BITS-1:0]      adev;
    logic [M_W-1:0]              m;
    logic [M_W:0]                m_up;
    logic signed [T_W-1:0]       lo_t, hi_t;
    logic signed [16:0]          dl, dh;
    logic signed [NL_W-1:0]      nl, nh;
    logic [PNUM_W-1:0]           pnum_l, pnum_h;

    always_comb begin
        dev  = $signed({1'b0, rdata}) - $signed({1'b0, r_zero[SAMPLE_BITS-1:0]});
        adev = dev[SAMPLE_BITS] ? SAMPLE_BITS'(-dev) : dev[SAMPLE_BITS-1:0];

        m    = M_W'(r_mult) * M_W'(r_s);
        m_up = {1'b0, m} + (M_W+1)'(255);
        lo_t = $signed(T_W'(r_zero)) - $signed(T_W'(m_up[M_W:8]));   // ceil
        hi_t = $signed(T_W'(r_zero)) + $signed(T_W'(m[M_W-1:8]));     // floor

        dl   = $signed({1'b0, r_zero}) - $signed({1'b0, r_min});
        dh   = $signed({1'b0, r_max}) - $signed({1'b0, r_zero});
        nl   = $signed(NL_W'(r_zero)) - NL_W'(r_lower);
        nh   = NL_W'(r_upper) - $signed(NL_W'(r_zero));
        pnum_l = PNUM_W'(nl[NL_W-2:0]) * PNUM_W'(100);
        pnum_h = PNUM_W'(nh[NL_W-2:0]) * PNUM_W'(100);
    end

    logic degen;
    assign degen = !r_zv || !r_rv || dl[16] || (dl == '0) || dh[16] || (dh == '0);

    // unit launch per state
    always_comb begin
        ds_ctl = '0;
        ds_num = '0;
        ds_den = '0;
        unique case (r_state)
            ST_MEAN: begin
                ds_ctl.start = !r_launch;
                ds_ctl.steps = STEP_W'(SUM_W);
                ds_num       = DS_W'(r_acc);
                ds_den       = DEN_W'(r_fill);
            end
            ST_VAR: begin
                ds_ctl.start = !r_launch;
                ds_ctl.steps = STEP_W'(DS_W);
                ds_num       = {r_acc, {FRAC2_W{1'b0}}};
                ds_den       = DEN_W'(r_fill);
            end
            ST_ROOT: begin
                ds_ctl.start   = !r_launch;
                ds_ctl.is_sqrt = 1'b1;
                ds_ctl.steps   = STEP_W'(ROOT_W);
                ds_num         = r_var;
            end
            ST_PL: begin
                ds_ctl.start = !r_launch && !degen && !nl[NL_W-1] && (nl != '0);
                ds_ctl.steps = STEP_W'(PNUM_W);
                ds_num       = DS_W'(pnum_l);
                ds_den       = DEN_W'(dl);
            end
            ST_PH: begin
                ds_ctl.start = !r_launch && !nh[NL_W-1] && (nh != '0);
                ds_ctl.steps = STEP_W'(PNUM_W);
                ds_num       = DS_W'(pnum_h);
                ds_den       = DEN_W'(dh);
            end
            default: begin
                ds_ctl = '0;
            end
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_W'(MULT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mult <= i_cfg_data;
        end
    end

    // ---------------- sequencer and state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_zero   <= '0;
            r_zv     <= 1'b0;
            r_lower  <= '0;
            r_upper  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_rv     <= 1'b0;
            r_cal    <= 1'b0;
            r_cnt    <= '0;
            r_launch <= 1'b0;
            r_pend   <= 1'b0;
            r_pend2  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result loaded in ST_FIN takes over the slot
            if (out_take && r_state != ST_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_idx    <= '0;
                        r_acc    <= '0;
                        r_pend   <= 1'b0;
                        r_pend2  <= 1'b0;
                        r_launch <= 1'b0;
                        r_pct    <= '0;
                        if (i_mode) begin
                            r_state <= ST_PL;
                            r_cnt   <= CNT_W'(WINDOW);
                            r_cal   <= 1'b1;
                            r_lower <= BND_W'(r_zero);
                            r_upper <= BND_W'(r_zero);
                        end else begin
                            // window statistics only while calibrating and once zero is set
                            r_state <= (r_cal && r_zv) ? ST_SUM : ST_PL;
                            r_wp <= (r_wp == IDX_W'(WINDOW - 1)) ? '0 : r_wp + IDX_W'(1);
                            if (r_fill < FILL_W'(WINDOW)) begin
                                r_fill <= r_fill + FILL_W'(1);
                            end
                            if (!r_rv) begin
                                r_min <= 16'(x);
                                r_max <= 16'(x);
                                r_rv  <= 1'b1;
                            end else begin
                                if (16'(x) < r_min) r_min <= 16'(x);
                                if (16'(x) > r_max) r_max <= 16'(x);
                            end
                            if (r_cal) begin
                                if (!r_zv) begin
                                    // first calibrating sample seeds zero and bounds
                                    r_zero  <= 16'(x);
                                    r_lower <= BND_W'(16'(x));
                                    r_upper <= BND_W'(16'(x));
                                    r_zv    <= 1'b1;
                                end
                                r_cnt <= r_cnt - CNT_W'(1);
                                if (r_cnt == CNT_W'(1)) begin
                                    r_cal <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_SUM: begin
                    r_pend <= (r_idx < r_fill);
                    if (r_idx < r_fill) begin
                        r_idx <= r_idx + FILL_W'(1);
                    end
                    if (r_pend) begin
                        r_acc <= r_acc + SQ_W'(rdata);
                    end
                    if (r_idx == r_fill && !r_pend) begin
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (ds_done) begin
                        r_launch <= 1'b0;
                        r_zero   <= ds_q[15:0];
                        r_acc    <= '0;
                        r_idx    <= '0;
                        r_state  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_pend  <= (r_idx < r_fill);
                    r_pend2 <= r_pend;
                    if (r_idx < r_fill) begin
                        r_idx <= r_idx + FILL_W'(1);
                    end
                    if (r_pend) begin
                        r_sqv <= (2*SAMPLE_BITS)'(adev) * (2*SAMPLE_BITS)'(adev);
                    end
                    if (r_pend2) begin
                        r_acc <= r_acc + SQ_W'(r_sqv);
                    end
                    if (r_idx == r_fill && !r_pend && !r_pend2) begin
                        r_state <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (ds_done) begin
                        r_launch <= 1'b0;
                        r_var    <= ds_q;
                        r_state  <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (!r_launch) begin
                        r_launch <= 1'b1;
                    end else if (ds_done) begin
                        r_launch <= 1'b0;
                        r_s      <= ds_q[ROOT_W-1:0];
                        r_state  <= ST_BND;
                    end
                end
                ST_BND: begin
                    r_lower <= sat_bnd(lo_t);
                    r_upper <= sat_bnd(hi_t);
                    r_state <= ST_PL;
                end
                ST_PL: begin
                    if (!r_launch) begin
                        if (degen) begin
                            r_pct   <= '0;
                            r_state <= ST_FIN;
                        end else if (ds_ctl.start) begin
                            r_launch <= 1'b1;
                        end else begin
                            r_state <= ST_PH;
                        end
                    end else if (ds_done) begin
                        r_launch <= 1'b0;
                        r_pct    <= cap_pct(ds_q);
                        r_state  <= ST_PH;
                    end
                end
                ST_PH: begin
                    if (!r_launch) begin
                        if (ds_ctl.start) begin
                            r_launch <= 1'b1;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end else if (ds_done) begin
                        r_launch <= 1'b0;
                        if (cap_pct(ds_q) > r_pct) begin
                            r_pct <= cap_pct(ds_q);
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result register load
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && slot_free) begin
            r_o_zero  <= r_zero;
            r_o_zv    <= r_zv;
            r_o_lower <= r_lower;
            r_o_upper <= r_upper;
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            r_o_rv    <= r_rv;
            r_o_cal   <= r_cal;
            r_o_cnt   <= r_cnt;
            r_o_pct   <= r_pct;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_zero_position    = r_o_zero;
    assign o_zero_valid       = r_o_zv;
    assign o_deadzone_lower   = r_o_lower;
    assign o_deadzone_upper   = r_o_upper;
    assign o_range_minimum    = r_o_min;
    assign o_range_maximum    = r_o_max;
    assign o_range_valid      = r_o_rv;
    assign o_calibrating      = r_o_cal;
    assign o_countdown        = r_o_cnt;
    assign o_deadzone_percent = r_o_pct;

endmodule

/* rtl/jdc_ring.sv */
// ----------------------------------------------------------------------------
// jdc_ring
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module jdc_ring (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [jdc_pkg::IDX_W-1:0]           i_waddr,
    input  logic [jdc_pkg::SAMPLE_BITS-1:0]     i_wdata,
    input  logic [jdc_pkg::IDX_W-1:0]           i_raddr,
    output logic [jdc_pkg::SAMPLE_BITS-1:0]     o_rdata
);
    import jdc_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/jdc_divsqrt.sv */
// ----------------------------------------------------------------------------
// jdc_divsqrt
// Shared restoring unit: one quotient bit or one root bit per cycle.
// ----------------------------------------------------------------------------
module jdc_divsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jdc_pkg::t_ds_ctl            i_ctl,
    input  logic [jdc_pkg::DS_W-1:0]    i_num,
    input  logic [jdc_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [jdc_pkg::DS_W-1:0]    o_q
);
    import jdc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_sqrt;
    logic [STEP_W-1:0] r_cnt;
    logic [DS_W-1:0]   r_q;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DEN_W-1:0]  r_den;

    logic [REM_W-1:0]  shifted, operand;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb begin
        if (r_sqrt) begin
            shifted = {r_rem[REM_W-3:0], r_q[DS_W-1 -: 2]};
            operand = {1'b0, r_root, 2'b01};
        end else begin
            shifted = {r_rem[REM_W-2:0], r_q[DS_W-1]};
            operand = REM_W'(r_den);
        end
        diff = {1'b0, shifted} - {1'b0, operand};
        ge   = ~diff[REM_W];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == STEP_W'(1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sqrt <= i_ctl.is_sqrt;
            r_cnt  <= i_ctl.steps;
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
            r_q    <= i_ctl.is_sqrt ? i_num : (i_num << (STEP_W'(DS_W) - i_ctl.steps));
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            r_rem <= ge ? diff[REM_W-1:0] : shifted;
            if (r_sqrt) begin
                r_q    <= {r_q[DS_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], ge};
            end else begin
                r_q <= {r_q[DS_W-2:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sqrt ? DS_W'(r_root) : r_q;

endmodule

/* rtl/jdc_checker.sv */
// ----------------------------------------------------------------------------
// jdc_checker
// Port-level checks of the deadzone calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module jdc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [15:0]                         o_zero_position,
    input  logic                                o_zero_valid,
    input  logic signed [jdc_pkg::BND_W-1:0]    o_deadzone_lower,
    input  logic signed [jdc_pkg::BND_W-1:0]    o_deadzone_upper,
    input  logic [15:0]                         o_range_minimum,
    input  logic [15:0]                         o_range_maximum,
    input  logic                                o_range_valid,
    input  logic                                o_calibrating,
    input  logic [jdc_pkg::CNT_W-1:0]           o_countdown,
    input  logic [jdc_pkg::PCT_W-1:0]           o_deadzone_percent
);

    // a stalled result beat holds its valid, zero position and percent
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_zero_position)
            && $stable(o_deadzone_percent))
        else $error("result beat changed while stalled");

    // countdown is parked at zero outside a run
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_calibrating |-> o_countdown == '0)
        else $error("countdown nonzero outside calibration");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_valid |-> o_range_minimum <= o_range_maximum)
        else $error("range minimum above maximum");

    a_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_deadzone_lower <= o_deadzone_upper)
        else $error("deadzone bounds crossed");

    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_zero_valid || !o_range_valid) |-> o_deadzone_percent == '0)
        else $error("percent reported without zero or range");

endmodule

bind joystick_deadzone_calibrator jdc_checker u_jdc_checker (.*);

/* tb/tb_joystick_deadzone_calibrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_deadzone_calibrator
// Drives sample and start beats and multiplier writes, with random gaps and
// output stalls, predicts every result beat from a behavioral model of the
// calibrator and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module tb_joystick_deadzone_calibrator;
    import jdc_pkg::*;

    localparam int N_RANDOM  = 530;
    localparam int WDOG_MAX  = 20000;
    localparam int EXP_DEPTH = 1024;
    localparam int DIR_DEPTH = 32;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_START  = 1'b1;
    localparam longint BMAX = 1048575;
    localparam longint BMIN = -1048576;

    typedef struct packed {
        logic [15:0]             zero;
        logic                    zvalid;
        logic signed [BND_W-1:0] lower;
        logic signed [BND_W-1:0] upper;
        logic [15:0]             rmin;
        logic [15:0]             rmax;
        logic                    rvalid;
        logic                    cal;
        logic [CNT_W-1:0]        cnt;
        logic [PCT_W-1:0]        pct;
    } t_result;

    // directed row: a beat, or a config write when is_cfg is set
    typedef struct {
        bit          is_cfg;
        logic        mode;
        logic [15:0] smp;
        logic [3:0]  mult;
        bit          has_exp;
        t_result     exp_val;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [MULT_W-1:0] i_cfg_data;
    logic i_valid, o_stall, i_mode;
    logic [15:0] i_sample;
    logic o_valid, i_stall;
    logic [15:0] o_zero_position, o_range_minimum, o_range_maximum;
    logic o_zero_valid, o_range_valid, o_calibrating;
    logic signed [BND_W-1:0] o_deadzone_lower, o_deadzone_upper;
    logic [CNT_W-1:0] o_countdown;
    logic [PCT_W-1:0] o_deadzone_percent;

    joystick_deadzone_calibrator u_dut (.*);

    // ---------------- calibrator shadow state ----------------
    logic [15:0] win_ring [WINDOW];
    int          win_wp, win_fill;
    longint      cal_zero, cal_lo, cal_hi;
    bit          cal_zvalid, cal_rvalid, cal_active;
    longint      cal_min, cal_max;
    int          cal_cnt;
    int          cal_mult;

    // predicted beats, written at exp_wr and consumed at exp_rd
    t_result exp_mem [EXP_DEPTH];
    int      exp_wr, exp_rd;
    int      n_fail, n_shown;
    int      n_results, wdog;
    bit      stim_done;

    function automatic longint clamp21(longint v);
        if (v > BMAX) return BMAX;
        if (v < BMIN) return BMIN;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // mean and stdev based bounds over the filled part of the ring
    task automatic refresh_bounds();
        longint unsigned acc, sq, sd, m;
        longint d;
        acc = 0;
        sq  = 0;
        for (int i = 0; i < win_fill; i++) acc += win_ring[i];
        cal_zero = acc / win_fill;
        for (int i = 0; i < win_fill; i++) begin
            d = longint'(win_ring[i]) - cal_zero;
            sq += d * d;
        end
        sd = int_sqrt((sq << 16) / win_fill);
        m  = cal_mult * sd;
        cal_lo = clamp21(cal_zero - longint'((m + 255) >> 8));
        cal_hi = clamp21(cal_zero + longint'(m >> 8));
    endtask

    function automatic int deadzone_pct();
        longint dl, dh, nl, nh, pl, ph, p;
        if (!cal_zvalid || !cal_rvalid) return 0;
        dl = cal_zero - cal_min;
        dh = cal_max - cal_zero;
        if (dl <= 0 || dh <= 0) return 0;
        nl = cal_zero - cal_lo;
        nh = cal_hi - cal_zero;
        pl = (nl > 0) ? nl * 100 / dl : 0;
        ph = (nh > 0) ? nh * 100 / dh : 0;
        p  = (pl > ph) ? pl : ph;
        return (p > PCT_CAP) ? PCT_CAP : int'(p);
    endfunction

    // advance the shadow state by one beat and queue the resulting beat
    task automatic predict_beat(logic mode, logic [15:0] x);
        t_result r;
        if (mode == MODE_START) begin
            cal_cnt    = WINDOW;
            cal_active = 1;
            cal_lo     = cal_zero;
            cal_hi     = cal_zero;
        end else begin
            win_ring[win_wp] = x;
            win_wp = (win_wp + 1 >= WINDOW) ? 0 : win_wp + 1;
            if (win_fill < WINDOW) win_fill++;
            if (cal_active) begin
                if (!cal_zvalid) begin
                    cal_zero   = x;
                    cal_lo     = x;
                    cal_hi     = x;
                    cal_zvalid = 1;
                end else begin
                    refresh_bounds();
                end
            end
            if (!cal_rvalid) begin
                cal_min    = x;
                cal_max    = x;
                cal_rvalid = 1;
            end else begin
                if (x < cal_min) cal_min = x;
                if (x > cal_max) cal_max = x;
            end
            if (cal_active) begin
                cal_cnt = (cal_cnt - 1) & 9'h1FF;
                if (cal_cnt == 0) cal_active = 0;
            end
        end
        r.zero   = cal_zero[15:0];
        r.zvalid = cal_zvalid;
        r.lower  = cal_lo[BND_W-1:0];
        r.upper  = cal_hi[BND_W-1:0];
        r.rmin   = cal_min[15:0];
        r.rmax   = cal_max[15:0];
        r.rvalid = cal_rvalid;
        r.cal    = cal_active;
        r.cnt    = cal_cnt[CNT_W-1:0];
        r.pct    = PCT_W'(deadzone_pct());
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // ---------------- clock, reset ----------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // ---------------- sender side ----------------
    task automatic send_beat(logic mode, logic [15:0] x);
        @(negedge i_clk);
        i_mode   <= mode;
        i_sample <= x;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_beat(mode, x);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_mult(logic [3:0] v);
        drain();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cal_mult = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic idle_gap();
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
    endtask

    t_row dir_tbl [DIR_DEPTH];
    int   n_dir;

    task automatic add_beat(logic mode, logic [15:0] x);
        t_row r;
        r = '{default: '0};
        r.mode = mode;
        r.smp  = x;
        dir_tbl[n_dir] = r;
        n_dir++;
    endtask

    task automatic add_checked(logic mode, logic [15:0] x, t_result e);
        t_row r;
        r = '{default: '0};
        r.mode    = mode;
        r.smp     = x;
        r.has_exp = 1;
        r.exp_val = e;
        dir_tbl[n_dir] = r;
        n_dir++;
    endtask

    task automatic add_cfg(logic [3:0] v);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.mult   = v;
        dir_tbl[n_dir] = r;
        n_dir++;
    endtask

    initial begin
        t_result e;
        int kind, base, spread, burst;
        logic [15:0] x;

        i_rst_n = 0; i_valid = 0; i_mode = 0; i_sample = 0;
        i_cfg_valid = 0; i_cfg_data = 0; i_stall = 0;
        win_wp = 0; win_fill = 0; cal_zero = 0; cal_lo = 0; cal_hi = 0;
        cal_zvalid = 0; cal_rvalid = 0; cal_active = 0;
        cal_min = 0; cal_max = 0; cal_cnt = 0; cal_mult = MULT_RESET;
        n_fail = 0; n_shown = 0; stim_done = 0;
        exp_wr = 0; exp_rd = 0; n_dir = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: start with no zero, first zero, extremes
        e = '{default: '0};
        e.cal = 1; e.cnt = CNT_W'(WINDOW);
        add_checked(MODE_START, 16'hFFFF, e);        // start before any sample
        e.zvalid = 1; e.rvalid = 1; e.cnt = CNT_W'(WINDOW - 1);
        add_checked(MODE_SAMPLE, 16'h0000, e);      // first sample sets zero
        add_beat(MODE_SAMPLE, 16'hFFFF);
        add_beat(MODE_SAMPLE, 16'h0000);
        add_beat(MODE_SAMPLE, 16'hAAAA);
        add_beat(MODE_SAMPLE, 16'h5555);
        add_cfg(4'd15);
        add_beat(MODE_SAMPLE, 16'hFFFF);
        add_beat(MODE_SAMPLE, 16'h0001);
        add_beat(MODE_START, 16'h1234);              // restart during a run
        add_beat(MODE_SAMPLE, 16'h8000);
        add_cfg(4'd0);
        add_beat(MODE_SAMPLE, 16'h7FFF);
        add_beat(MODE_SAMPLE, 16'h8001);
        add_cfg(4'd1);
        add_beat(MODE_SAMPLE, 16'h4000);
        add_beat(MODE_SAMPLE, 16'hC000);

        for (int i = 0; i < n_dir; i++) begin
            if (dir_tbl[i].is_cfg) begin
                write_mult(dir_tbl[i].mult);
            end else begin
                send_beat(dir_tbl[i].mode, dir_tbl[i].smp);
                // typed-in rows must agree with the predictor too
                if (dir_tbl[i].has_exp
                    && exp_mem[(exp_wr - 1) % EXP_DEPTH] !== dir_tbl[i].exp_val) begin
                    n_fail++;
                    $display("directed row %0d: typed %h, predicted %h",
                             i, dir_tbl[i].exp_val, exp_mem[(exp_wr - 1) % EXP_DEPTH]);
                end
            end
        end

        // random: mostly calibration runs over a clustered window, with noise
        for (int n = 0; n < N_RANDOM; ) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                write_mult(4'($urandom_range(0, 15)));
            end else if (kind < 20) begin
                send_beat(MODE_START, 16'($urandom));
                n++;
                idle_gap();
            end else begin
                base   = $urandom_range(0, 65535);
                spread = (kind < 60) ? $urandom_range(0, 300) : 65535;
                burst  = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < N_RANDOM; b++) begin
                    if (spread == 65535) x = 16'($urandom);
                    else x = 16'(base + $urandom_range(0, spread) - spread / 2);
                    send_beat(MODE_SAMPLE, x);
                    n++;
                    idle_gap();
                end
            end
        end
        stim_done = 1;
    end

    // ---------------- receiver side ----------------
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 9) < 3) begin
                g = gap_len();
                if (g > 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_zero_position, o_zero_valid, o_deadzone_lower, o_deadzone_upper,
                    o_range_minimum, o_range_maximum, o_range_valid, o_calibrating,
                    o_countdown, o_deadzone_percent};
            if (exp_wr == exp_rd) begin
                n_fail++;
                if (n_shown < 10) begin
                    n_shown++;
                    $display("unexpected result beat %h", got);
                end
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want) begin
                    n_fail++;
                    if (n_shown < 10) begin
                        n_shown++;
                        $display("result %0d mismatch", n_results);
                        $display("  exp zero %h/%b lo %0d hi %0d min %h max %h rv %b cal %b cnt %0d pct %0d",
                                 want.zero, want.zvalid, want.lower, want.upper, want.rmin,
                                 want.rmax, want.rvalid, want.cal, want.cnt, want.pct);
                        $display("  got zero %h/%b lo %0d hi %0d min %h max %h rv %b cal %b cnt %0d pct %0d",
                                 got.zero, got.zvalid, got.lower, got.upper, got.rmin,
                                 got.rmax, got.rvalid, got.cal, got.cnt, got.pct);
                    end
                end
            end
            n_results++;
        end
    end

    // watchdog on cycles without any handshake on input, output or configuration
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial begin
        n_results = 0;
        wdog = 0;
        fork
            begin
                wait (stim_done);
                while (exp_wr != exp_rd) @(posedge i_clk);
                repeat (400) @(posedge i_clk);
            end
            begin
                wait (wdog >= WDOG_MAX);
                n_fail++;
            end
        join_any
        if (n_fail == 0 && exp_wr == exp_rd)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* joystick_deadzone_calibrator.f */
rtl/jdc_pkg.sv
rtl/jdc_ring.sv
rtl/jdc_divsqrt.sv
rtl/joystick_deadzone_calibrator.sv
rtl/jdc_checker.sv
tb/tb_joystick_deadzone_calibrator.sv
